FILE: hdl/fnvm_pkg.sv
// Shared types, constants and hash functions of the file-name FNV matcher.
package fnvm_pkg;

  localparam int TABLE_DEPTH_DEF = 256;
  localparam int NAME_LIMIT_DEF  = 128;
  localparam int QUEUE_DEPTH     = 2;

  localparam int HASH_W      = 64;
  localparam int BYTE_W      = 8;
  localparam int REQ_W       = 2;
  localparam int KIND_W      = 2;
  localparam int IN_DATA_W   = 72;
  localparam int OUT_FLAGS_W = 6;
  localparam int OUT_DATA_W  = 136;
  localparam int OUT_PAD_W   = OUT_DATA_W - OUT_FLAGS_W - 2 * HASH_W;

  localparam logic [HASH_W-1:0] FNV_BASIS = 64'hCBF2_9CE4_8422_2325;
  localparam logic [BYTE_W-1:0] DOT_CHAR  = 8'h2E;
  localparam logic [BYTE_W-1:0] UPPER_A   = 8'h41;
  localparam logic [BYTE_W-1:0] UPPER_Z   = 8'h5A;
  localparam logic [BYTE_W-1:0] CASE_GAP  = 8'd32;

  typedef enum logic [REQ_W-1:0] {
    REQ_BYTE     = 2'd0,
    REQ_ADD_EXT  = 2'd1,
    REQ_ADD_NOTE = 2'd2,
    REQ_CLEAR    = 2'd3
  } req_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_VERDICT = 2'd0,
    KIND_LOAD    = 2'd1,
    KIND_CLEAR   = 2'd2
  } kind_t;

  // A request byte with the last mark set travels as op REQ_BYTE.
  typedef struct packed {
    req_t              op;
    logic [HASH_W-1:0] hash_a;
    logic [HASH_W-1:0] hash_b;
    logic              has_ext;
    logic              too_long;
  } cmd_t;

  function automatic logic [BYTE_W-1:0] fold_case(input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] r;
    r = b;
    if (b >= UPPER_A && b <= UPPER_Z) begin
      r = b + CASE_GAP;
    end
    return r;
  endfunction

  // The shift-and-add sum is the product with the FNV-64 prime 2^40 + 0x1B3.
  function automatic logic [HASH_W-1:0] fnv_fold(input logic [HASH_W-1:0] h,
                                                 input logic [BYTE_W-1:0] b);
    logic [HASH_W-1:0] x;
    x = h ^ {{(HASH_W - BYTE_W){1'b0}}, b};
    return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
  endfunction

endpackage

FILE: hdl/fnvm_front.sv
// Front end: accepts requests, hashes name bytes and queues commands for the back end.
module fnvm_front #(
  parameter int NAME_LIMIT = fnvm_pkg::NAME_LIMIT_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [fnvm_pkg::IN_DATA_W-1:0]   in_tdata,
  input  logic [fnvm_pkg::REQ_W-1:0]       in_tuser,
  input  logic                             in_tlast,
  input  logic                             q_full,
  output logic                             push,
  output fnvm_pkg::cmd_t                   push_cmd
);

  localparam int LEN_W = $clog2(NAME_LIMIT + 1);

  logic [fnvm_pkg::HASH_W-1:0] name_hash_r, name_hash_nxt;
  logic [fnvm_pkg::HASH_W-1:0] ext_acc_r, ext_acc_nxt;
  logic                        dot_r, dot_nxt;
  logic [LEN_W-1:0]            len_r, len_nxt;

  logic                        accept;
  fnvm_pkg::req_t              req;
  logic [fnvm_pkg::BYTE_W-1:0] raw_byte;
  logic [fnvm_pkg::BYTE_W-1:0] low_byte;
  logic [fnvm_pkg::HASH_W-1:0] table_hash;
  logic [fnvm_pkg::HASH_W-1:0] nh, eh, ext_base;
  logic                        dot_n;
  logic [LEN_W-1:0]            len_n;

  assign in_tready  = !q_full;
  assign accept     = in_tvalid && in_tready;
  assign req        = fnvm_pkg::req_t'(in_tuser);
  assign raw_byte   = in_tdata[fnvm_pkg::BYTE_W-1:0];
  assign table_hash = in_tdata[fnvm_pkg::IN_DATA_W-1:fnvm_pkg::BYTE_W];

  always_comb begin
    low_byte = fnvm_pkg::fold_case(raw_byte);
    nh       = fnvm_pkg::fnv_fold(name_hash_r, low_byte);
    ext_base = (raw_byte == fnvm_pkg::DOT_CHAR) ? fnvm_pkg::FNV_BASIS : ext_acc_r;
    dot_n    = dot_r || (raw_byte == fnvm_pkg::DOT_CHAR);
    eh       = dot_n ? fnvm_pkg::fnv_fold(ext_base, low_byte) : ext_acc_r;
    len_n    = (len_r < LEN_W'(NAME_LIMIT)) ? len_r + 1'b1 : len_r;
  end

  always_comb begin
    name_hash_nxt = name_hash_r;
    ext_acc_nxt   = ext_acc_r;
    dot_nxt       = dot_r;
    len_nxt       = len_r;
    if (accept && req == fnvm_pkg::REQ_BYTE) begin
      if (in_tlast) begin
        name_hash_nxt = fnvm_pkg::FNV_BASIS;
        ext_acc_nxt   = '0;
        dot_nxt       = 1'b0;
        len_nxt       = '0;
      end else begin
        name_hash_nxt = nh;
        ext_acc_nxt   = eh;
        dot_nxt       = dot_n;
        len_nxt       = len_n;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      name_hash_r <= fnvm_pkg::FNV_BASIS;
      ext_acc_r   <= '0;
      dot_r       <= 1'b0;
      len_r       <= '0;
    end else begin
      name_hash_r <= name_hash_nxt;
      ext_acc_r   <= ext_acc_nxt;
      dot_r       <= dot_nxt;
      len_r       <= len_nxt;
    end
  end

  always_comb begin
    push              = accept && (req != fnvm_pkg::REQ_BYTE || in_tlast);
    push_cmd.op       = req;
    push_cmd.hash_a   = (req == fnvm_pkg::REQ_BYTE) ? nh : table_hash;
    push_cmd.hash_b   = eh;
    push_cmd.has_ext  = dot_n;
    push_cmd.too_long = (len_n == LEN_W'(NAME_LIMIT));
  end

endmodule

FILE: hdl/fnvm_cmd_q.sv
// Short command queue between the front end and the back end.
module fnvm_cmd_q (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  fnvm_pkg::cmd_t push_cmd,
  input  logic           pop,
  output fnvm_pkg::cmd_t pop_cmd,
  output logic           full,
  output logic           empty
);

  localparam int PTR_W = $clog2(fnvm_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(fnvm_pkg::QUEUE_DEPTH + 1);

  fnvm_pkg::cmd_t   q_mem_r [fnvm_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CNT_W'(fnvm_pkg::QUEUE_DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_cmd = q_mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

FILE: hdl/fnvm_back.sv
// Back end: owns both hash tables, scans them for name verdicts and table loads and drives the result register.
module fnvm_back #(
  parameter int TABLE_DEPTH = fnvm_pkg::TABLE_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            q_empty,
  input  fnvm_pkg::cmd_t                  q_cmd,
  output logic                            q_pop,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [fnvm_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic [fnvm_pkg::KIND_W-1:0]     out_tuser
);

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [2:0] {
    BS_IDLE = 3'b001,
    BS_SCAN = 3'b010,
    BS_FIN  = 3'b100
  } back_state_t;

  back_state_t                     state_r, state_nxt;
  fnvm_pkg::cmd_t                  cmd_r;
  logic [CNT_W-1:0]                scan_r, scan_nxt;
  logic [CNT_W-1:0]                note_cnt_r, note_cnt_nxt;
  logic [CNT_W-1:0]                ext_cnt_r, ext_cnt_nxt;
  logic                            chk_v_r, chk_v_nxt;
  logic [CNT_W-1:0]                chk_idx_r;
  logic                            note_hit_r, note_hit_nxt;
  logic                            ext_hit_r, ext_hit_nxt;
  logic                            out_tvalid_r, out_tvalid_nxt;
  logic [fnvm_pkg::OUT_DATA_W-1:0] out_tdata_r;
  logic [fnvm_pkg::KIND_W-1:0]     out_tuser_r;

  logic [fnvm_pkg::HASH_W-1:0]     note_mem [TABLE_DEPTH];
  logic [fnvm_pkg::HASH_W-1:0]     ext_mem  [TABLE_DEPTH];
  logic [fnvm_pkg::HASH_W-1:0]     note_q_r, ext_q_r;

  logic [CNT_W-1:0]                lim;
  logic                            rd_en;
  logic                            out_load;
  logic [fnvm_pkg::HASH_W-1:0]     ext_key;
  logic                            note_wr, ext_wr;
  logic                            load_full;
  logic                            nm, em;
  fnvm_pkg::kind_t                 res_kind;
  logic [fnvm_pkg::OUT_DATA_W-1:0] res_data;

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;
  assign out_load   = (state_r == BS_FIN) && (!out_tvalid_r || out_tready);
  assign ext_key    = (cmd_r.op == fnvm_pkg::REQ_ADD_EXT) ? cmd_r.hash_a : cmd_r.hash_b;

  always_comb begin
    case (cmd_r.op)
      fnvm_pkg::REQ_BYTE:     lim = cmd_r.too_long ? '0 :
                                    ((note_cnt_r > ext_cnt_r) ? note_cnt_r : ext_cnt_r);
      fnvm_pkg::REQ_ADD_EXT:  lim = ext_cnt_r;
      fnvm_pkg::REQ_ADD_NOTE: lim = note_cnt_r;
      default:                lim = '0;
    endcase
  end

  assign rd_en = (state_r == BS_SCAN) && (scan_r < lim);

  always_comb begin
    state_nxt    = state_r;
    scan_nxt     = scan_r;
    chk_v_nxt    = 1'b0;
    note_hit_nxt = note_hit_r;
    ext_hit_nxt  = ext_hit_r;
    q_pop        = 1'b0;

    if (chk_v_r) begin
      if (chk_idx_r < note_cnt_r && note_q_r == cmd_r.hash_a &&
          (cmd_r.op == fnvm_pkg::REQ_BYTE || cmd_r.op == fnvm_pkg::REQ_ADD_NOTE)) begin
        note_hit_nxt = 1'b1;
      end
      if (chk_idx_r < ext_cnt_r && ext_q_r == ext_key &&
          ((cmd_r.op == fnvm_pkg::REQ_BYTE && cmd_r.has_ext) ||
           cmd_r.op == fnvm_pkg::REQ_ADD_EXT)) begin
        ext_hit_nxt = 1'b1;
      end
    end

    case (state_r)
      BS_IDLE: begin
        if (!q_empty) begin
          q_pop        = 1'b1;
          scan_nxt     = '0;
          note_hit_nxt = 1'b0;
          ext_hit_nxt  = 1'b0;
          state_nxt    = BS_SCAN;
        end
      end
      BS_SCAN: begin
        if (rd_en) begin
          chk_v_nxt = 1'b1;
          scan_nxt  = scan_r + 1'b1;
        end else begin
          state_nxt = BS_FIN;
        end
      end
      BS_FIN: begin
        if (out_load) begin
          state_nxt = BS_IDLE;
        end
      end
      default: begin
        state_nxt = BS_IDLE;
      end
    endcase
  end

  always_comb begin
    note_wr      = 1'b0;
    ext_wr       = 1'b0;
    load_full    = 1'b0;
    note_cnt_nxt = note_cnt_r;
    ext_cnt_nxt  = ext_cnt_r;
    nm           = note_hit_r && !cmd_r.too_long;
    em           = ext_hit_r && cmd_r.has_ext && !cmd_r.too_long;
    res_kind     = fnvm_pkg::KIND_VERDICT;
    res_data     = '0;
    case (cmd_r.op)
      fnvm_pkg::REQ_BYTE: begin
        res_kind = fnvm_pkg::KIND_VERDICT;
        res_data = {{fnvm_pkg::OUT_PAD_W{1'b0}},
                    (cmd_r.has_ext ? cmd_r.hash_b : {fnvm_pkg::HASH_W{1'b0}}),
                    cmd_r.hash_a, 1'b0, cmd_r.too_long, cmd_r.has_ext, em, nm, nm || em};
      end
      fnvm_pkg::REQ_ADD_EXT: begin
        res_kind  = fnvm_pkg::KIND_LOAD;
        load_full = !ext_hit_r && (ext_cnt_r == CNT_W'(TABLE_DEPTH));
        ext_wr    = out_load && !ext_hit_r && !load_full;
        if (ext_wr) begin
          ext_cnt_nxt = ext_cnt_r + 1'b1;
        end
        res_data  = {{(fnvm_pkg::OUT_DATA_W - fnvm_pkg::OUT_FLAGS_W){1'b0}},
                     load_full, 5'b00000};
      end
      fnvm_pkg::REQ_ADD_NOTE: begin
        res_kind  = fnvm_pkg::KIND_LOAD;
        load_full = !note_hit_r && (note_cnt_r == CNT_W'(TABLE_DEPTH));
        note_wr   = out_load && !note_hit_r && !load_full;
        if (note_wr) begin
          note_cnt_nxt = note_cnt_r + 1'b1;
        end
        res_data  = {{(fnvm_pkg::OUT_DATA_W - fnvm_pkg::OUT_FLAGS_W){1'b0}},
                     load_full, 5'b00000};
      end
      default: begin
        res_kind = fnvm_pkg::KIND_CLEAR;
        if (out_load) begin
          note_cnt_nxt = '0;
          ext_cnt_nxt  = '0;
        end
      end
    endcase
  end

  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    if (out_load) begin
      out_tvalid_nxt = 1'b1;
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= BS_IDLE;
      scan_r       <= '0;
      chk_v_r      <= 1'b0;
      note_hit_r   <= 1'b0;
      ext_hit_r    <= 1'b0;
      note_cnt_r   <= '0;
      ext_cnt_r    <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      scan_r       <= scan_nxt;
      chk_v_r      <= chk_v_nxt;
      note_hit_r   <= note_hit_nxt;
      ext_hit_r    <= ext_hit_nxt;
      note_cnt_r   <= note_cnt_nxt;
      ext_cnt_r    <= ext_cnt_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd_r <= q_cmd;
    end
    chk_idx_r <= scan_r;
    if (out_load) begin
      out_tdata_r <= res_data;
      out_tuser_r <= res_kind;
    end
  end

  always_ff @(posedge clk) begin
    if (note_wr) begin
      note_mem[note_cnt_r[IDX_W-1:0]] <= cmd_r.hash_a;
    end
  end

  always_ff @(posedge clk) begin
    if (ext_wr) begin
      ext_mem[ext_cnt_r[IDX_W-1:0]] <= cmd_r.hash_a;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      note_q_r <= note_mem[scan_r[IDX_W-1:0]];
      ext_q_r  <= ext_mem[scan_r[IDX_W-1:0]];
    end
  end

endmodule

FILE: hdl/filename_fnv_ioc_matcher.sv
// Top level of the file-name FNV-1a matcher: front end, command queue and back end.
// Each name byte is lower-cased and folded into the whole-name and extension hashes as
// it is accepted, so bytes inside a name stream at one per cycle while the queue is not
// full. The byte marked last, a table load and a clear each become a command in a
// two-entry queue; the back end then scans its table memories one entry per cycle
// through a single read port. A verdict scans max(note_count, ext_count) entries, a
// load scans the entries of its target table, and a clear scans none. A too-long name
// skips the scan. The input stalls only while the queue is full.
module filename_fnv_ioc_matcher #(
  parameter int TABLE_DEPTH = fnvm_pkg::TABLE_DEPTH_DEF,
  parameter int NAME_LIMIT  = fnvm_pkg::NAME_LIMIT_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // name_byte [7:0], table_hash [71:8]
  input  logic [fnvm_pkg::IN_DATA_W-1:0]  in_tdata,
  // req_type [1:0]
  input  logic [fnvm_pkg::REQ_W-1:0]      in_tuser,
  input  logic                            in_tlast,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // suspicious [0], note_match [1], extension_match [2], has_extension [3],
  // name_too_long [4], table_full [5], full_name_hash [69:6], extension_hash [133:70]
  output logic [fnvm_pkg::OUT_DATA_W-1:0] out_tdata,
  // result_kind [1:0]
  output logic [fnvm_pkg::KIND_W-1:0]     out_tuser
);

  fnvm_pkg::cmd_t push_cmd;
  fnvm_pkg::cmd_t pop_cmd;
  logic           push;
  logic           pop;
  logic           q_full;
  logic           q_empty;

  fnvm_front #(
    .NAME_LIMIT (NAME_LIMIT)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .q_full    (q_full),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  fnvm_cmd_q u_cmd_q (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .full     (q_full),
    .empty    (q_empty)
  );

  fnvm_back #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_cmd      (pop_cmd),
    .q_pop      (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps
// Testbench of the file-name FNV matcher: stream driver, reply predictor and checker.
module tb_top;

  localparam int TABLE_DEPTH = fnvm_pkg::TABLE_DEPTH_DEF;
  localparam int NAME_LIMIT  = fnvm_pkg::NAME_LIMIT_DEF;
  localparam int HASH_W      = fnvm_pkg::HASH_W;
  localparam int BYTE_W      = fnvm_pkg::BYTE_W;
  localparam int WATCH_LIMIT = 5000;
  localparam int TAIL_CYCLES = 600;
  localparam int RANDOM_REQS = 40;
  localparam logic [HASH_W-1:0] HASH_MULT = 64'd1099511628211;
  localparam logic [BYTE_W-1:0] LOWER_A   = 8'h61;
  localparam logic [BYTE_W-1:0] LOWER_Z   = 8'h7A;
  localparam logic [BYTE_W-1:0] DIGIT_0   = 8'h30;

  typedef logic [BYTE_W-1:0] byte_q_t[$];

  typedef struct packed {
    fnvm_pkg::req_t    op;
    logic [BYTE_W-1:0] nb;
    logic              lst;
    logic [HASH_W-1:0] key;
  } req_item_t;

  typedef struct packed {
    fnvm_pkg::kind_t   kind;
    logic              susp;
    logic              note_hit;
    logic              ext_hit;
    logic              has_ext;
    logic              too_long;
    logic              full;
    logic [HASH_W-1:0] name_hash;
    logic [HASH_W-1:0] ext_digest;
  } reply_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  logic [fnvm_pkg::IN_DATA_W-1:0]  in_tdata = '0;
  logic [fnvm_pkg::REQ_W-1:0]      in_tuser = fnvm_pkg::REQ_BYTE;
  logic                            in_tlast = 1'b0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [fnvm_pkg::OUT_DATA_W-1:0] out_tdata;
  logic [fnvm_pkg::KIND_W-1:0]     out_tuser;

  req_item_t req_q[$];
  reply_t    reply_q[$];
  int        reqs_total = 0;
  int        reqs_seen = 0;
  int        errors = 0;
  int        send_gap = 0;
  int        stall_left = 0;
  int        calm_left = 0;
  logic      calm = 1'b0;
  int        idle_cycles = 0;

  logic [HASH_W-1:0] cur_name_hash = fnvm_pkg::FNV_BASIS;
  logic [HASH_W-1:0] cur_ext_acc = '0;
  logic              dot_found = 1'b0;
  int                byte_count = 0;
  logic [HASH_W-1:0] note_keys[TABLE_DEPTH];
  logic [HASH_W-1:0] ext_keys[TABLE_DEPTH];
  int                note_used = 0;
  int                ext_used = 0;

  string stems[8] = '{"readme", "how_to_decrypt", "photo", "invoice", "restore_files",
                      "notes", "backup", "a"};
  string exts[6] = '{".txt", ".locked", ".pdf", ".enc", ".docx", "."};

  filename_fnv_ioc_matcher i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [BYTE_W-1:0] lower_byte(input logic [BYTE_W-1:0] b);
    if (b >= fnvm_pkg::UPPER_A && b <= fnvm_pkg::UPPER_Z) begin
      return b ^ fnvm_pkg::CASE_GAP;
    end
    return b;
  endfunction

  function automatic logic [HASH_W-1:0] fnv_step(input logic [HASH_W-1:0] h,
                                                 input logic [BYTE_W-1:0] c);
    return (h ^ {{(HASH_W - BYTE_W){1'b0}}, c}) * HASH_MULT;
  endfunction

  function automatic byte_q_t str_bytes(input string s);
    byte_q_t n;
    int i;
    for (i = 0; i < s.len(); i++) begin
      n.push_back(s[i]);
    end
    return n;
  endfunction

  function automatic logic [HASH_W-1:0] hash_of(input byte_q_t n, input bit want_ext);
    logic [HASH_W-1:0] h;
    logic [HASH_W-1:0] e;
    bit dot;
    int i;
    h = fnvm_pkg::FNV_BASIS;
    e = '0;
    dot = 1'b0;
    for (i = 0; i < n.size(); i++) begin
      h = fnv_step(h, lower_byte(n[i]));
      if (n[i] == fnvm_pkg::DOT_CHAR) begin
        dot = 1'b1;
        e = fnvm_pkg::FNV_BASIS;
      end
      if (dot) begin
        e = fnv_step(e, lower_byte(n[i]));
      end
    end
    return want_ext ? e : h;
  endfunction

  function automatic byte_q_t pool_name();
    byte_q_t n;
    n = str_bytes(stems[$urandom_range(0, 7)]);
    if ($urandom_range(0, 9) < 7) begin
      n = {n, str_bytes(exts[$urandom_range(0, 5)])};
    end
    return n;
  endfunction

  function automatic logic [BYTE_W-1:0] rand_char();
    int r;
    r = $urandom_range(0, 19);
    if (r < 10) return LOWER_A + 8'($urandom_range(0, 25));
    if (r < 14) return fnvm_pkg::UPPER_A + 8'($urandom_range(0, 25));
    if (r < 15) return fnvm_pkg::DOT_CHAR;
    if (r < 17) return DIGIT_0 + 8'($urandom_range(0, 9));
    return 8'($urandom_range(0, 255));
  endfunction

  // Half the names are built from known stems and extensions with random case, so that the
  // loaded tables get hit; the rest are random bytes, a few of them past the length limit.
  function automatic byte_q_t rand_name();
    byte_q_t n;
    int len;
    int i;
    if ($urandom_range(0, 99) < 50) begin
      n = pool_name();
      for (i = 0; i < n.size(); i++) begin
        if (n[i] >= LOWER_A && n[i] <= LOWER_Z && $urandom_range(0, 2) == 0) begin
          n[i] = n[i] ^ fnvm_pkg::CASE_GAP;
        end
      end
    end else begin
      len = ($urandom_range(0, 99) < 98) ? $urandom_range(1, 14) : $urandom_range(120, 135);
      for (i = 0; i < len; i++) begin
        n.push_back(rand_char());
      end
    end
    return n;
  endfunction

  function automatic logic [HASH_W-1:0] rand_key(input bit is_note);
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) begin
      return is_note ? hash_of(pool_name(), 1'b0)
                     : hash_of(str_bytes(exts[$urandom_range(0, 5)]), 1'b1);
    end
    if (r == 7) return '1;
    if (r == 8) return '0;
    return {$urandom, $urandom};
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic add_req(input fnvm_pkg::req_t op, input logic [BYTE_W-1:0] nb,
                         input logic lst, input logic [HASH_W-1:0] key);
    req_item_t it;
    it.op = op;
    it.nb = nb;
    it.lst = lst;
    it.key = key;
    req_q.push_back(it);
    reqs_total++;
  endtask

  task automatic send_load(input fnvm_pkg::req_t op, input logic [HASH_W-1:0] key);
    add_req(op, 8'($urandom), 1'($urandom), key);
  endtask

  task automatic send_clear();
    add_req(fnvm_pkg::REQ_CLEAR, 8'($urandom), 1'($urandom), {$urandom, $urandom});
  endtask

  task automatic send_table_op();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) begin
      send_clear();
    end else if (r < 10) begin
      send_load(fnvm_pkg::REQ_ADD_NOTE, rand_key(1'b1));
    end else begin
      send_load(fnvm_pkg::REQ_ADD_EXT, rand_key(1'b0));
    end
  endtask

  // Table requests may fall between the bytes of a name with the given percentage.
  task automatic send_name(input byte_q_t n, input bit ends, input int mix_pct);
    int i;
    for (i = 0; i < n.size(); i++) begin
      if ($urandom_range(0, 99) < mix_pct) begin
        send_table_op();
      end
      add_req(fnvm_pkg::REQ_BYTE, n[i], ends && (i == n.size() - 1), {$urandom, $urandom});
    end
  endtask

  function automatic bit in_table(input bit is_note, input logic [HASH_W-1:0] key);
    int n;
    int i;
    n = is_note ? note_used : ext_used;
    for (i = 0; i < n; i++) begin
      if ((is_note ? note_keys[i] : ext_keys[i]) == key) begin
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  task automatic predict_reply(input fnvm_pkg::req_t op, input logic [BYTE_W-1:0] nb,
                               input logic lst, input logic [HASH_W-1:0] key);
    reply_t r;
    logic [BYTE_W-1:0] c;
    bit is_note;
    r = '0;
    case (op)
      fnvm_pkg::REQ_BYTE: begin
        c = lower_byte(nb);
        cur_name_hash = fnv_step(cur_name_hash, c);
        if (nb == fnvm_pkg::DOT_CHAR) begin
          dot_found = 1'b1;
          cur_ext_acc = fnvm_pkg::FNV_BASIS;
        end
        if (dot_found) begin
          cur_ext_acc = fnv_step(cur_ext_acc, c);
        end
        if (byte_count < NAME_LIMIT) begin
          byte_count++;
        end
        if (lst) begin
          r.kind = fnvm_pkg::KIND_VERDICT;
          r.too_long = (byte_count >= NAME_LIMIT);
          if (!r.too_long) begin
            r.note_hit = in_table(1'b1, cur_name_hash);
            r.ext_hit = dot_found && in_table(1'b0, cur_ext_acc);
          end
          r.susp = r.note_hit | r.ext_hit;
          r.has_ext = dot_found;
          r.name_hash = cur_name_hash;
          r.ext_digest = dot_found ? cur_ext_acc : '0;
          reply_q.push_back(r);
          cur_name_hash = fnvm_pkg::FNV_BASIS;
          cur_ext_acc = '0;
          dot_found = 1'b0;
          byte_count = 0;
        end
      end
      fnvm_pkg::REQ_CLEAR: begin
        note_used = 0;
        ext_used = 0;
        r.kind = fnvm_pkg::KIND_CLEAR;
        reply_q.push_back(r);
      end
      default: begin
        r.kind = fnvm_pkg::KIND_LOAD;
        is_note = (op == fnvm_pkg::REQ_ADD_NOTE);
        if (!in_table(is_note, key)) begin
          if ((is_note ? note_used : ext_used) >= TABLE_DEPTH) begin
            r.full = 1'b1;
          end else if (is_note) begin
            note_keys[note_used] = key;
            note_used++;
          end else begin
            ext_keys[ext_used] = key;
            ext_used++;
          end
        end
        reply_q.push_back(r);
      end
    endcase
  endtask

  task automatic check_field(input string fname, input logic [HASH_W-1:0] want,
                             input logic [HASH_W-1:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t ns: %s mismatch, expected %h, actual %h", $time, fname, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (calm_left == 0) begin
      calm <= ($urandom_range(0, 3) == 0);
      calm_left <= $urandom_range(20, 300);
    end else begin
      calm_left <= calm_left - 1;
    end
  end

  always @(posedge clk) begin : drive_proc
    req_item_t cur;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (send_gap > 0) begin
        in_tvalid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (req_q.size() > 0) begin
        cur = req_q.pop_front();
        in_tvalid <= 1'b1;
        in_tuser <= cur.op;
        in_tdata <= {cur.key, cur.nb};
        in_tlast <= cur.lst;
        send_gap <= calm ? 0 : pick_gap();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_tready <= 1'b1;
      if (!calm && $urandom_range(0, 3) == 0) begin
        stall_left <= pick_gap();
      end
    end
  end

  always @(posedge clk) begin : check_proc
    reply_t want;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        predict_reply(fnvm_pkg::req_t'(in_tuser), in_tdata[BYTE_W-1:0], in_tlast,
                      in_tdata[fnvm_pkg::IN_DATA_W-1:BYTE_W]);
        reqs_seen++;
      end
      if (out_tvalid && out_tready) begin
        if (reply_q.size() == 0) begin
          errors++;
          $display("%0t ns: result with nothing expected, actual kind %0d data %h",
                   $time, out_tuser, out_tdata);
        end else begin
          want = reply_q.pop_front();
          check_field("result_kind", 64'(want.kind), 64'(out_tuser));
          check_field("suspicious", 64'(want.susp), 64'(out_tdata[0]));
          check_field("note_match", 64'(want.note_hit), 64'(out_tdata[1]));
          check_field("extension_match", 64'(want.ext_hit), 64'(out_tdata[2]));
          check_field("has_extension", 64'(want.has_ext), 64'(out_tdata[3]));
          check_field("name_too_long", 64'(want.too_long), 64'(out_tdata[4]));
          check_field("table_full", 64'(want.full), 64'(out_tdata[5]));
          check_field("full_name_hash", want.name_hash, out_tdata[69:6]);
          check_field("extension_hash", want.ext_digest, out_tdata[133:70]);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCH_LIMIT) begin
      $display("** filename_fnv_ioc_matcher: FAILED **");
      $finish;
    end
  end

  initial begin : stim_proc
    byte_q_t nm;
    int i;
    int start_cnt;

    send_clear();
    send_name(str_bytes("a"), 1'b1, 0);
    send_load(fnvm_pkg::REQ_ADD_EXT, hash_of(str_bytes(".txt"), 1'b1));
    send_load(fnvm_pkg::REQ_ADD_NOTE, hash_of(str_bytes("readme.txt"), 1'b0));
    send_load(fnvm_pkg::REQ_ADD_EXT, '1);
    send_load(fnvm_pkg::REQ_ADD_NOTE, '0);
    send_load(fnvm_pkg::REQ_ADD_EXT, hash_of(str_bytes(".txt"), 1'b1));
    send_name(str_bytes("README.TXT"), 1'b1, 0);
    send_name(str_bytes("Photo.Txt"), 1'b1, 0);
    send_name(str_bytes("x.txt.gz"), 1'b1, 0);
    send_name(str_bytes("noext"), 1'b1, 0);
    send_name(str_bytes("file."), 1'b1, 0);
    send_name('{8'h00}, 1'b1, 0);
    send_name('{8'hFF}, 1'b1, 0);
    send_name('{8'h40, 8'h5B, 8'h41, 8'h5A, 8'h60, 8'h7B}, 1'b1, 0);

    // The table load arrives between the bytes of a name and must not disturb it.
    send_name(str_bytes("repo"), 1'b0, 0);
    send_load(fnvm_pkg::REQ_ADD_EXT, hash_of(str_bytes(".md"), 1'b1));
    send_name(str_bytes("rt.MD"), 1'b1, 0);

    nm = {};
    for (i = 0; i < NAME_LIMIT; i++) begin
      nm.push_back(LOWER_A + 8'(i % 26));
    end
    send_load(fnvm_pkg::REQ_ADD_NOTE, hash_of(nm, 1'b0));
    send_name(nm, 1'b1, 0);

    send_name(str_bytes("ab"), 1'b0, 0);
    send_clear();
    send_name(str_bytes("c.txt"), 1'b1, 0);

    // The note table is filled to the last entry and then loaded past it.
    for (i = 0; i < TABLE_DEPTH - 1; i++) begin
      send_load(fnvm_pkg::REQ_ADD_NOTE, {$urandom, 32'(i)});
    end
    send_load(fnvm_pkg::REQ_ADD_NOTE, hash_of(str_bytes("invoice.pdf"), 1'b0));
    send_load(fnvm_pkg::REQ_ADD_NOTE, {$urandom, $urandom});
    send_load(fnvm_pkg::REQ_ADD_NOTE, hash_of(str_bytes("invoice.pdf"), 1'b0));
    send_load(fnvm_pkg::REQ_ADD_EXT, hash_of(str_bytes(".pdf"), 1'b1));
    send_name(str_bytes("Invoice.PDF"), 1'b1, 0);
    send_name(str_bytes("other.pdf"), 1'b1, 0);
    send_clear();

    start_cnt = reqs_total;
    while (reqs_total - start_cnt < RANDOM_REQS) begin
      if ($urandom_range(0, 99) < 15) begin
        send_table_op();
      end else begin
        send_name(rand_name(), 1'b1, 4);
      end
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (reqs_seen < reqs_total) @(posedge clk);
    while (reply_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("** filename_fnv_ioc_matcher: PASSED **");
    end else begin
      $display("** filename_fnv_ioc_matcher: FAILED **");
    end
    $finish;
  end

endmodule

FILE: sim.f
hdl/fnvm_pkg.sv
hdl/fnvm_front.sv
hdl/fnvm_cmd_q.sv
hdl/fnvm_back.sv
hdl/filename_fnv_ioc_matcher.sv
test/tb_top.sv
